/* rtl/bpfa_pkg.sv */
// Shared types and constants for the bitmap page frame allocator.
// Used by bpfa_ctrl and bitmap_page_frame_allocator; depends on nothing.
`timescale 1ns / 1ps

package bpfa_pkg;

    // Address and page geometry.
    localparam int unsigned ADDR_W      = 32;
    localparam int unsigned PAGE_SHIFT  = 12;
    localparam logic [ADDR_W:0] PAGE_MASK = 33'h0_0000_0FFF;
    // Frame number width with one carry bit for the rounded-up start.
    localparam int unsigned FRAME_RAW_W = ADDR_W - PAGE_SHIFT + 1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ALLOC_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEM_TOP     = 2'd1;

    // Request kinds.
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Request word.
    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] free_address;
    } t_req;

    // Result word.
    typedef struct packed {
        logic [ADDR_W-1:0] page_address;
        logic              found;
    } t_res;

    // Memory strobes from the sequencer.
    typedef struct packed {
        logic re;
        logic we;
    } t_mem_ctl;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_FREE_RD,
        S_FREE_WR,
        S_SCAN_RD,
        S_SCAN_CHK
    } t_state;

endpackage

/* rtl/bpfa_find.sv */
// Find-first-free unit: masks one bitmap word to the usable range and finds its lowest free bit.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module bpfa_find #(
    parameter int unsigned WORD_BITS = 32
) (
    input  logic [WORD_BITS-1:0]         i_word,
    input  logic                         i_first,
    input  logic                         i_last,
    input  logic [$clog2(WORD_BITS)-1:0] i_lo_bit,
    input  logic [$clog2(WORD_BITS)-1:0] i_hi_bit,
    output logic                         o_hit,
    output logic [$clog2(WORD_BITS)-1:0] o_bit,
    output logic [WORD_BITS-1:0]         o_word
);

    localparam int unsigned BIW = $clog2(WORD_BITS);

    logic [WORD_BITS-1:0] lo_mask;
    logic [WORD_BITS-1:0] hi_mask;
    logic [WORD_BITS-1:0] cand;

    // Bits below the first frame or above the last frame do not take part.
    always_comb begin
        lo_mask = i_first ? ({WORD_BITS{1'b1}} << i_lo_bit) : {WORD_BITS{1'b1}};
        hi_mask = i_last ? ({WORD_BITS{1'b1}} >> (BIW'(WORD_BITS - 1) - i_hi_bit))
                         : {WORD_BITS{1'b1}};
        cand    = ~i_word & lo_mask & hi_mask;
    end

    // Priority search for the lowest free bit.
    always_comb begin
        o_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (cand[i]) begin
                o_bit = BIW'(i);
            end
        end
        o_hit  = |cand;
        o_word = i_word | ({{(WORD_BITS-1){1'b0}}, 1'b1} << o_bit);
    end

endmodule

/* rtl/bpfa_ctrl.sv */
// Sequencer of the allocator: clears the bitmap, scans it word by word and updates it.
// Depends on bpfa_pkg and bpfa_find.
`timescale 1ns / 1ps

module bpfa_ctrl #(
    parameter int unsigned FRAME_COUNT      = 1048576,
    parameter int unsigned BITMAP_WORD_BITS = 32,
    parameter int unsigned WIW              = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  bpfa_pkg::t_req                i_req,
    input  logic [bpfa_pkg::ADDR_W-1:0]   i_alloc_start,
    input  logic [bpfa_pkg::ADDR_W-1:0]   i_mem_top,
    output bpfa_pkg::t_mem_ctl            o_mem_ctl,
    output logic [WIW-1:0]                o_mem_addr,
    output logic [BITMAP_WORD_BITS-1:0]   o_mem_wdata,
    input  logic [BITMAP_WORD_BITS-1:0]   i_mem_rdata,
    output logic                          o_res_valid,
    output bpfa_pkg::t_res                o_res
);

    localparam int unsigned WB  = BITMAP_WORD_BITS;
    localparam int unsigned WORD_COUNT = (FRAME_COUNT + WB - 1) / WB;
    localparam int unsigned BIW = $clog2(WB);
    localparam int unsigned FNW = $clog2(FRAME_COUNT + 1);
    localparam int unsigned RW  = bpfa_pkg::FRAME_RAW_W;
    localparam int unsigned XW  = (RW > WIW + BIW) ? RW : WIW + BIW;
    localparam int unsigned AW  = bpfa_pkg::ADDR_W;

    bpfa_pkg::t_state r_state, n_state;

    logic           r_mode, n_mode;
    logic [RW-1:0]  r_frame, n_frame;
    logic [FNW-1:0] r_lo, n_lo;
    logic [FNW-1:0] r_hi, n_hi;
    logic [WIW-1:0] r_word, n_word;
    logic           r_res_valid, n_res_valid;
    bpfa_pkg::t_res r_res, n_res;

    logic [RW-1:0]  raw_lo;
    logic [RW-1:0]  raw_hi;
    logic [RW-1:0]  lim;
    logic [FNW-1:0] lo_c;
    logic [FNW-1:0] hi_c;
    logic [XW-1:0]  lo_x;
    logic [XW-1:0]  hl_x;
    logic [XW-1:0]  fr_x;
    logic           in_range;
    logic           empty;
    logic           last_word;
    logic           f_hit;
    logic [BIW-1:0] f_bit;
    logic [WB-1:0]  f_word;

    // Usable frame range from the registers, both ends clamped to the store.
    always_comb begin
        raw_lo = RW'(({1'b0, i_alloc_start} + bpfa_pkg::PAGE_MASK) >> bpfa_pkg::PAGE_SHIFT);
        raw_hi = RW'(i_mem_top >> bpfa_pkg::PAGE_SHIFT);
        lim    = RW'(FRAME_COUNT);
        lo_c   = (raw_lo > lim) ? FNW'(lim) : FNW'(raw_lo);
        hi_c   = (raw_hi > lim) ? FNW'(lim) : FNW'(raw_hi);
    end

    // Word and bit positions of the range ends and of the frame to free.
    always_comb begin
        lo_x      = XW'(r_lo);
        hl_x      = XW'(r_hi - FNW'(1));
        fr_x      = XW'(r_frame);
        empty     = (r_lo >= r_hi);
        in_range  = (RW'(r_lo) <= r_frame) && (r_frame < RW'(r_hi));
        last_word = (r_word == hl_x[BIW +: WIW]);
    end

    bpfa_find #(
        .WORD_BITS (WB)
    ) u_find (
        .i_word   (i_mem_rdata),
        .i_first  (r_word == lo_x[BIW +: WIW]),
        .i_last   (last_word),
        .i_lo_bit (lo_x[BIW-1:0]),
        .i_hi_bit (hl_x[BIW-1:0]),
        .o_hit    (f_hit),
        .o_bit    (f_bit),
        .o_word   (f_word)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            bpfa_pkg::S_CLEAR: begin
                if (r_word == WIW'(WORD_COUNT - 1)) begin
                    n_state = bpfa_pkg::S_IDLE;
                end
            end
            bpfa_pkg::S_IDLE: begin
                if (start) begin
                    n_state = bpfa_pkg::S_SETUP;
                end
            end
            bpfa_pkg::S_SETUP: begin
                if (r_mode == bpfa_pkg::MODE_FREE) begin
                    n_state = in_range ? bpfa_pkg::S_FREE_RD : bpfa_pkg::S_IDLE;
                end else begin
                    n_state = empty ? bpfa_pkg::S_IDLE : bpfa_pkg::S_SCAN_RD;
                end
            end
            bpfa_pkg::S_FREE_RD:  n_state = bpfa_pkg::S_FREE_WR;
            bpfa_pkg::S_FREE_WR:  n_state = bpfa_pkg::S_IDLE;
            bpfa_pkg::S_SCAN_RD:  n_state = bpfa_pkg::S_SCAN_CHK;
            bpfa_pkg::S_SCAN_CHK: begin
                n_state = (f_hit || last_word) ? bpfa_pkg::S_IDLE : bpfa_pkg::S_SCAN_RD;
            end
            default: n_state = bpfa_pkg::S_IDLE;
        endcase
    end

    // Datapath controls, memory strobes and next register values.
    always_comb begin
        n_mode      = r_mode;
        n_frame     = r_frame;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_word      = r_word;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_mem_ctl   = '0;
        o_mem_addr  = r_word;
        o_mem_wdata = f_word;
        busy        = (r_state != bpfa_pkg::S_IDLE);
        case (r_state)
            bpfa_pkg::S_CLEAR: begin
                o_mem_ctl.we = 1'b1;
                o_mem_wdata  = '0;
                n_word       = r_word + WIW'(1);
            end
            bpfa_pkg::S_IDLE: begin
                if (start) begin
                    n_mode  = i_req.mode;
                    n_frame = RW'(i_req.free_address >> bpfa_pkg::PAGE_SHIFT);
                    n_lo    = lo_c;
                    n_hi    = hi_c;
                end
            end
            bpfa_pkg::S_SETUP: begin
                n_word = lo_x[BIW +: WIW];
                if (r_mode == bpfa_pkg::MODE_ALLOC && empty) begin
                    n_res_valid = 1'b1;
                    n_res       = '0;
                end
            end
            bpfa_pkg::S_FREE_RD: begin
                o_mem_ctl.re = 1'b1;
                o_mem_addr   = fr_x[BIW +: WIW];
            end
            bpfa_pkg::S_FREE_WR: begin
                o_mem_ctl.we = 1'b1;
                o_mem_addr   = fr_x[BIW +: WIW];
                o_mem_wdata  = i_mem_rdata & ~({{(WB-1){1'b0}}, 1'b1} << fr_x[BIW-1:0]);
            end
            bpfa_pkg::S_SCAN_RD: begin
                o_mem_ctl.re = 1'b1;
            end
            bpfa_pkg::S_SCAN_CHK: begin
                if (f_hit) begin
                    // Claim the frame and report its address.
                    o_mem_ctl.we       = 1'b1;
                    n_res_valid        = 1'b1;
                    n_res.found        = 1'b1;
                    n_res.page_address = AW'({r_word, f_bit}) << bpfa_pkg::PAGE_SHIFT;
                end else if (last_word) begin
                    n_res_valid = 1'b1;
                    n_res       = '0;
                end else begin
                    n_word = r_word + WIW'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpfa_pkg::S_CLEAR;
            r_word      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_word      <= n_word;
            r_res_valid <= n_res_valid;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_frame <= n_frame;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_res   <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* rtl/bitmap_page_frame_allocator.sv */
// Top level of the bitmap first-fit page frame allocator: registers, bitmap memory, sequencer.
// Depends on bpfa_pkg and bpfa_ctrl.
`timescale 1ns / 1ps

// Channel   Direction  Ports                                      Word
// ------    ---------  -----------------------------------------  ----------------------
// request   in         start, busy, i_req                         mode, free_address
// result    out        o_res_valid, o_res                         page_address, found
// config    in         i_cfg_valid, o_cfg_ready, i_cfg_index,     register index, data
//                      i_cfg_data
//
// After reset the bitmap memory is cleared one word per cycle, with busy high; configuration
// writes are taken throughout. A free passes through setup, a read and a write of the bitmap
// word, or ends after setup when the frame lies outside the range. An allocate passes through
// setup and, unless the range is empty, then scans the bitmap words in order; each
// word costs a memory read and one pass through the find-first-free unit. The result strobe
// rises with busy falling; a free gives none. Results cannot be held off; none are buffered.

module bitmap_page_frame_allocator #(
    parameter int unsigned FRAME_COUNT      = 1048576,
    parameter int unsigned BITMAP_WORD_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  bpfa_pkg::t_req                     i_req,
    output logic                               o_res_valid,
    output bpfa_pkg::t_res                     o_res,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [bpfa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [bpfa_pkg::ADDR_W-1:0]        i_cfg_data
);

    localparam int unsigned WB         = BITMAP_WORD_BITS;
    localparam int unsigned WORD_COUNT = (FRAME_COUNT + WB - 1) / WB;
    localparam int unsigned WIW        = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

    logic [bpfa_pkg::ADDR_W-1:0] r_alloc_start;
    logic [bpfa_pkg::ADDR_W-1:0] r_mem_top;
    logic [WB-1:0]               r_mem [WORD_COUNT];
    logic [WB-1:0]               r_rdata;
    bpfa_pkg::t_mem_ctl          mem_ctl;
    logic [WIW-1:0]              mem_addr;
    logic [WB-1:0]               mem_wdata;

    assign o_cfg_ready = 1'b1;

    // Configuration registers; an unknown index is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alloc_start <= '0;
            r_mem_top     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bpfa_pkg::REG_ALLOC_START: r_alloc_start <= i_cfg_data;
                bpfa_pkg::REG_MEM_TOP:     r_mem_top     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Frame bitmap, one port, registered read.
    always_ff @(posedge i_clk) begin
        if (mem_ctl.we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        if (mem_ctl.re) begin
            r_rdata <= r_mem[mem_addr];
        end
    end

    bpfa_ctrl #(
        .FRAME_COUNT      (FRAME_COUNT),
        .BITMAP_WORD_BITS (WB),
        .WIW              (WIW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_req         (i_req),
        .i_alloc_start (r_alloc_start),
        .i_mem_top     (r_mem_top),
        .o_mem_ctl     (mem_ctl),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata),
        .i_mem_rdata   (r_rdata),
        .o_res_valid   (o_res_valid),
        .o_res         (o_res)
    );

    // A failed allocation always reports address zero.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.found) |-> (o_res.page_address == '0))
        else $error("failed allocation with nonzero address");

    // An accepted request makes the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    // A result is shown only once the sequencer is back to idle.
    a_res_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result strobe while busy");

    // The bitmap is never read and written in the same cycle.
    a_mem_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_ctl.re && mem_ctl.we))
        else $error("bitmap read and write in one cycle");

endmodule
